// ===== rtl/vna_pkg.sv =====
package vna_pkg;

    localparam int VERTICES_DEF = 1024;
    localparam int NORMALS_DEF  = 1024;

    localparam int IDX_W  = 10;
    localparam int POS_W  = 16;
    localparam int SUM_W  = 48;
    localparam int XP_W   = 35;
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 95;
    localparam int LEN_W  = 96;
    localparam int Q_W    = 29;
    localparam int ROOT_W = 15;
    localparam int UNIT_W = 16;

    localparam logic [1:0] OP_STORE = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } t_root_st;

endpackage

// ===== rtl/vna_ram.sv =====
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vna_mul.sv =====
module vna_mul import vna_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [MUL_W-1:0]  i_a,
    input  logic signed [MUL_W-1:0]  i_b,
    output logic signed [PROD_W-1:0] o_p
);

    logic signed [PROD_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/vna_root.sv =====
module vna_root import vna_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SQ_W-1:0]   i_sq,
    input  logic [LEN_W-1:0]  i_len,
    output t_root_st          o_st,
    output logic [ROOT_W-1:0] o_root
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_SQRT = 2'd2;

    logic [1:0]        r_phase;
    logic [4:0]        r_cnt;
    logic              r_done;
    logic [LEN_W-1:0]  r_den;
    logic [LEN_W-1:0]  r_rem;
    logic              r_nb;
    logic [Q_W:0]      r_q;
    logic [18:0]       r_srem;
    logic [ROOT_W-1:0] r_root;

    logic [LEN_W:0]    w_t;
    logic [LEN_W:0]    w_d;
    logic              w_ge;
    logic [18:0]       w_sr;
    logic [18:0]       w_test;
    logic              w_sge;

    assign w_t    = {r_rem, r_nb};
    assign w_d    = w_t - {1'b0, r_den};
    assign w_ge   = w_t >= {1'b0, r_den};
    assign w_sr   = {r_srem[16:0], r_q[Q_W:Q_W-1]};
    assign w_test = {2'b00, r_root, 2'b01};
    assign w_sge  = w_sr >= w_test;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_phase <= P_DIV;
                        r_cnt   <= 5'(Q_W - 1);
                    end
                end
                P_DIV: begin
                    if (r_cnt == '0) begin
                        r_phase <= P_SQRT;
                        r_cnt   <= 5'(ROOT_W - 1);
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                P_SQRT: begin
                    if (r_cnt == '0) begin
                        r_phase <= P_IDLE;
                        r_done  <= 1'b1;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                default: r_phase <= P_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_phase == P_IDLE && i_start) begin
            r_den  <= i_len;
            r_rem  <= LEN_W'(i_sq >> 1);
            r_nb   <= i_sq[0];
            r_q    <= '0;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_phase == P_DIV) begin
            r_rem <= w_ge ? w_d[LEN_W-1:0] : w_t[LEN_W-1:0];
            r_nb  <= 1'b0;
            r_q   <= {r_q[Q_W-1:0], w_ge};
        end else if (r_phase == P_SQRT) begin
            r_srem <= w_sge ? (w_sr - w_test) : w_sr;
            r_root <= {r_root[ROOT_W-2:0], w_sge};
            r_q    <= {r_q[Q_W-2:0], 2'b00};
        end
    end

    assign o_st.busy = (r_phase != P_IDLE);
    assign o_st.done = r_done;
    assign o_root    = r_root;

endmodule

// ===== rtl/vertex_normal_accumulator.sv =====
// Store vertex and clear normal: written straight from idle, and the block stays idle.
// Accumulate triangle: 3 vertex reads, 6 products on the shared multiplier,
// then 3 read-modify-writes (read state, then write state).
// Read normal: the shared multiplier squares, then the shared divide/square-root
// unit runs 29 + 15 steps per component.
// Synchronous reset, then a clearing pass over all NORMALS entries of the sum store.
module vertex_normal_accumulator import vna_pkg::*; #(
    parameter int VERTICES = VERTICES_DEF,
    parameter int NORMALS  = NORMALS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_operation,
    input  logic [IDX_W-1:0]         i_vertex_a,
    input  logic [IDX_W-1:0]         i_vertex_b,
    input  logic [IDX_W-1:0]         i_vertex_c,
    input  logic [IDX_W-1:0]         i_normal_a,
    input  logic [IDX_W-1:0]         i_normal_b,
    input  logic [IDX_W-1:0]         i_normal_c,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [POS_W-1:0]  i_pos_z,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [UNIT_W-1:0] o_unit_x,
    output logic signed [UNIT_W-1:0] o_unit_y,
    output logic signed [UNIT_W-1:0] o_unit_z,
    output logic                     o_zero_length,
    output logic                     o_saturated
);

    localparam int VAW   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
    localparam int NAW   = (NORMALS > 1) ? $clog2(NORMALS) : 1;
    localparam int VTX_W = 3 * POS_W;
    localparam int ACC_W = 3 * SUM_W + 1;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_VRD   = 4'd2;
    localparam logic [3:0] S_XP    = 4'd3;
    localparam logic [3:0] S_RMA   = 4'd4;
    localparam logic [3:0] S_RMB   = 4'd5;
    localparam logic [3:0] S_NRD   = 4'd6;
    localparam logic [3:0] S_NLAT  = 4'd7;
    localparam logic [3:0] S_SQ    = 4'd8;
    localparam logic [3:0] S_ROOT  = 4'd9;
    localparam logic [3:0] S_RWAIT = 4'd10;
    localparam logic [3:0] S_PUT   = 4'd11;

    function automatic logic [SUM_W:0] sat_add(input logic signed [SUM_W-1:0] s,
                                               input logic signed [XP_W-1:0] n);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
        if (t[SUM_W] != t[SUM_W-1]) begin
            return {1'b1, t[SUM_W], {(SUM_W-1){~t[SUM_W]}}};
        end
        return {1'b0, t[SUM_W-1:0]};
    endfunction

    function automatic logic [3:0] sq_step(input logic [3:0] j);
        logic [3:0] r;
        case (j)
            4'd0:    r = {2'd0, 2'd0};
            4'd1:    r = {2'd0, 2'd1};
            4'd2:    r = {2'd0, 2'd2};
            4'd3:    r = {2'd1, 2'd0};
            4'd4:    r = {2'd1, 2'd1};
            4'd5:    r = {2'd1, 2'd2};
            4'd6:    r = {2'd2, 2'd0};
            4'd7:    r = {2'd2, 2'd1};
            default: r = {2'd2, 2'd2};
        endcase
        return r;
    endfunction

    logic [3:0]               r_state;
    logic [3:0]               n_state;
    logic [3:0]               r_cnt;
    logic [NAW-1:0]           r_clr;
    logic [IDX_W-1:0]         r_vidx [3];
    logic [IDX_W-1:0]         r_nidx [3];
    logic                     r_vok;
    logic signed [POS_W-1:0]  r_p [3][3];
    logic signed [XP_W-1:0]   r_n [3];
    logic [SUM_W-1:0]         r_mag [3];
    logic                     r_neg [3];
    logic                     r_sat;
    logic [SQ_W-1:0]          r_sq [3];
    logic [LEN_W-1:0]         r_len;
    logic signed [UNIT_W-1:0] r_u [3];
    logic                     r_zl;
    logic                     r_ovalid;
    logic signed [UNIT_W-1:0] r_ox;
    logic signed [UNIT_W-1:0] r_oy;
    logic signed [UNIT_W-1:0] r_oz;
    logic                     r_ozl;
    logic                     r_osat;

    logic                     w_accept;
    logic [1:0]               w_vk;
    logic [1:0]               w_nk;
    logic [1:0]               w_pk;
    logic                     w_vok_ra;
    logic                     w_nok_k;
    logic                     w_nok_a;
    logic                     w_nok_in;
    logic                     w_vin_ok;
    logic [VAW-1:0]           w_vra;
    logic [VTX_W-1:0]         w_vrd;
    logic                     w_awe;
    logic [NAW-1:0]           w_awa;
    logic [ACC_W-1:0]         w_awd;
    logic [NAW-1:0]           w_ara;
    logic [ACC_W-1:0]         w_ard;
    logic [SUM_W:0]           w_sx;
    logic [SUM_W:0]           w_sy;
    logic [SUM_W:0]           w_sz;
    logic signed [16:0]       w_e1 [3];
    logic signed [16:0]       w_e2 [3];
    logic signed [MUL_W-1:0]  w_ma;
    logic signed [MUL_W-1:0]  w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [XP_W-1:0]   w_p35;
    logic [3:0]               w_j;
    logic [3:0]               w_iss;
    logic [3:0]               w_col;
    logic [SQ_W-1:0]          w_contrib;
    logic                     w_root_start;
    t_root_st                 w_root_st;
    logic [ROOT_W-1:0]        w_root;
    logic                     w_put;

    assign w_accept  = i_in_valid && (r_state == S_IDLE);
    assign w_vk      = (r_cnt < 4'd3) ? r_cnt[1:0] : 2'd2;
    assign w_nk      = (r_cnt < 4'd3) ? r_cnt[1:0] : 2'd2;
    assign w_pk      = r_cnt[1:0] - 2'd1;
    assign w_vok_ra  = ({7'd0, r_vidx[w_vk]} < 17'(VERTICES));
    assign w_nok_k   = ({7'd0, r_nidx[w_nk]} < 17'(NORMALS));
    assign w_nok_a   = ({7'd0, r_nidx[0]} < 17'(NORMALS));
    assign w_nok_in  = ({7'd0, i_normal_a} < 17'(NORMALS));
    assign w_vin_ok  = ({7'd0, i_vertex_a} < 17'(VERTICES));
    assign w_vra     = VAW'(r_vidx[w_vk]);
    assign w_put     = (r_state == S_PUT) && (!r_ovalid || !i_out_stall);

    vna_ram #(.WIDTH(VTX_W), .DEPTH(VERTICES)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_operation == OP_STORE && w_vin_ok),
        .i_waddr (VAW'(i_vertex_a)),
        .i_wdata ({i_pos_z, i_pos_y, i_pos_x}),
        .i_raddr (w_vra),
        .o_rdata (w_vrd)
    );

    vna_ram #(.WIDTH(ACC_W), .DEPTH(NORMALS)) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (w_awe),
        .i_waddr (w_awa),
        .i_wdata (w_awd),
        .i_raddr (w_ara),
        .o_rdata (w_ard)
    );

    assign w_sx = sat_add(w_ard[SUM_W-1:0], r_n[0]);
    assign w_sy = sat_add(w_ard[2*SUM_W-1:SUM_W], r_n[1]);
    assign w_sz = sat_add(w_ard[3*SUM_W-1:2*SUM_W], r_n[2]);

    always_comb begin
        w_awe = 1'b0;
        w_awa = NAW'(r_nidx[w_nk]);
        w_awd = '0;
        w_ara = NAW'(r_nidx[0]);
        unique case (r_state)
            S_CLR: begin
                w_awe = 1'b1;
                w_awa = r_clr;
            end
            S_IDLE: begin
                w_awe = w_accept && i_operation == OP_CLEAR && w_nok_in;
                w_awa = NAW'(i_normal_a);
            end
            S_RMA: begin
                w_ara = NAW'(r_nidx[w_nk]);
            end
            S_RMB: begin
                w_awe = 1'b1;
                w_awd = {w_ard[ACC_W-1] | w_sx[SUM_W] | w_sy[SUM_W] | w_sz[SUM_W],
                         w_sz[SUM_W-1:0], w_sy[SUM_W-1:0], w_sx[SUM_W-1:0]};
            end
            default: begin
                w_awe = 1'b0;
            end
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_e1[k] = 17'(r_p[1][k]) - 17'(r_p[0][k]);
            w_e2[k] = 17'(r_p[2][k]) - 17'(r_p[0][k]);
        end
    end

    assign w_iss = sq_step(r_cnt);
    assign w_j   = r_cnt - 4'd1;
    assign w_col = sq_step(w_j);

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_XP) begin
            case (r_cnt)
                4'd0: begin w_ma = MUL_W'(w_e1[1]); w_mb = MUL_W'(w_e2[2]); end
                4'd1: begin w_ma = MUL_W'(w_e1[2]); w_mb = MUL_W'(w_e2[1]); end
                4'd2: begin w_ma = MUL_W'(w_e1[2]); w_mb = MUL_W'(w_e2[0]); end
                4'd3: begin w_ma = MUL_W'(w_e1[0]); w_mb = MUL_W'(w_e2[2]); end
                4'd4: begin w_ma = MUL_W'(w_e1[0]); w_mb = MUL_W'(w_e2[1]); end
                default: begin w_ma = MUL_W'(w_e1[1]); w_mb = MUL_W'(w_e2[0]); end
            endcase
        end else begin
            case (w_iss[1:0])
                2'd0: begin
                    w_ma = {1'b0, r_mag[w_iss[3:2]][SUM_W-1:24]};
                    w_mb = {1'b0, r_mag[w_iss[3:2]][SUM_W-1:24]};
                end
                2'd1: begin
                    w_ma = {1'b0, r_mag[w_iss[3:2]][SUM_W-1:24]};
                    w_mb = {1'b0, r_mag[w_iss[3:2]][23:0]};
                end
                default: begin
                    w_ma = {1'b0, r_mag[w_iss[3:2]][23:0]};
                    w_mb = {1'b0, r_mag[w_iss[3:2]][23:0]};
                end
            endcase
        end
    end

    vna_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_prod)
    );

    assign w_p35 = w_prod[XP_W-1:0];

    always_comb begin
        case (w_col[1:0])
            2'd0:    w_contrib = SQ_W'({w_prod[47:0], 48'd0});
            2'd1:    w_contrib = SQ_W'({w_prod[47:0], 25'd0});
            default: w_contrib = SQ_W'(w_prod[47:0]);
        endcase
    end

    assign w_root_start = (r_state == S_ROOT) && (r_len != '0);

    vna_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_sq    (r_sq[w_nk]),
        .i_len   (r_len),
        .o_st    (w_root_st),
        .o_root  (w_root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:   if (r_clr == NAW'(NORMALS - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept && i_operation == OP_ACCUM) n_state = S_VRD;
                if (w_accept && i_operation == OP_READ)  n_state = S_NRD;
            end
            S_VRD:   if (r_cnt == 4'd3) n_state = S_XP;
            S_XP:    if (r_cnt == 4'd6) n_state = S_RMA;
            S_RMA: begin
                if (w_nok_k) n_state = S_RMB;
                else if (r_cnt == 4'd2) n_state = S_IDLE;
            end
            S_RMB:   n_state = (r_cnt == 4'd2) ? S_IDLE : S_RMA;
            S_NRD:   n_state = w_nok_a ? S_NLAT : S_PUT;
            S_NLAT:  n_state = S_SQ;
            S_SQ:    if (r_cnt == 4'd9) n_state = S_ROOT;
            S_ROOT:  n_state = (r_len == '0) ? S_PUT : S_RWAIT;
            S_RWAIT: begin
                if (w_root_st.done) n_state = (r_cnt == 4'd2) ? S_PUT : S_ROOT;
            end
            S_PUT:   if (w_put) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_cnt    <= '0;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr <= r_clr + NAW'(1);
            end
            if (r_state != n_state && !(r_state == S_RMA && n_state == S_RMB)
                    && r_state != S_RMB && r_state != S_ROOT && r_state != S_RWAIT) begin
                r_cnt <= '0;
            end else if (r_state == S_RMB || r_state == S_RWAIT) begin
                if (w_root_st.done || r_state == S_RMB) r_cnt <= r_cnt + 4'd1;
            end else if (r_state == S_RMA) begin
                if (!w_nok_k) r_cnt <= r_cnt + 4'd1;
            end else if (r_state == S_VRD || r_state == S_XP || r_state == S_SQ) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (w_put) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vok <= w_vok_ra;
        if (w_accept) begin
            r_vidx[0] <= i_vertex_a;
            r_vidx[1] <= i_vertex_b;
            r_vidx[2] <= i_vertex_c;
            r_nidx[0] <= i_normal_a;
            r_nidx[1] <= i_normal_b;
            r_nidx[2] <= i_normal_c;
        end
        if (r_state == S_VRD && r_cnt != 4'd0) begin
            r_p[w_pk][0] <= r_vok ? w_vrd[POS_W-1:0] : '0;
            r_p[w_pk][1] <= r_vok ? w_vrd[2*POS_W-1:POS_W] : '0;
            r_p[w_pk][2] <= r_vok ? w_vrd[3*POS_W-1:2*POS_W] : '0;
        end
        if (r_state == S_XP && r_cnt != 4'd0) begin
            if (!w_j[0]) begin
                r_n[w_j[2:1]] <= w_p35;
            end else begin
                r_n[w_j[2:1]] <= r_n[w_j[2:1]] - w_p35;
            end
        end
        if (r_state == S_NRD && !w_nok_a) begin
            r_sat <= 1'b0;
            r_zl  <= 1'b1;
            for (int k = 0; k < 3; k++) r_u[k] <= '0;
        end
        if (r_state == S_NLAT) begin
            for (int k = 0; k < 3; k++) begin
                r_neg[k] <= w_ard[SUM_W*k+SUM_W-1];
                r_mag[k] <= w_ard[SUM_W*k+SUM_W-1] ? (SUM_W'(0) - w_ard[SUM_W*k +: SUM_W])
                                                   : w_ard[SUM_W*k +: SUM_W];
                r_sq[k]  <= '0;
            end
            r_sat <= w_ard[ACC_W-1];
            r_len <= '0;
        end
        if (r_state == S_SQ && r_cnt != 4'd0) begin
            r_sq[w_col[3:2]] <= r_sq[w_col[3:2]] + w_contrib;
            r_len            <= r_len + LEN_W'(w_contrib);
        end
        if (r_state == S_ROOT) begin
            r_zl <= (r_len == '0);
            if (r_len == '0) begin
                for (int k = 0; k < 3; k++) r_u[k] <= '0;
            end
        end
        if (r_state == S_RWAIT && w_root_st.done) begin
            r_u[w_nk] <= r_neg[w_nk] ? (UNIT_W'(0) - UNIT_W'(w_root)) : UNIT_W'(w_root);
        end
        if (w_put) begin
            r_ox   <= r_u[0];
            r_oy   <= r_u[1];
            r_oz   <= r_u[2];
            r_ozl  <= r_zl;
            r_osat <= r_sat;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_ovalid;
    assign o_unit_x      = r_ox;
    assign o_unit_y      = r_oy;
    assign o_unit_z      = r_oz;
    assign o_zero_length = r_ozl;
    assign o_saturated   = r_osat;

    a_root_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_start |-> !w_root_st.busy)
        else $error("root unit started while busy");

    a_root_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_st.done |-> (r_state == S_RWAIT))
        else $error("root result outside wait state");

    a_zero_len_comps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ozl) |-> (r_ox == '0 && r_oy == '0 && r_oz == '0))
        else $error("zero-length word with nonzero components");

    a_no_rmw_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RMB) |=> (r_state == S_RMA || r_state == S_IDLE))
        else $error("sum write not followed by next corner");

endmodule
